// ===== hdl/adll_pkg.sv =====
// Package: shared types, widths and codes for the array doubly linked list.
`default_nettype none
package adll_pkg;

  localparam int CAPACITY  = 128;
  localparam int NAME_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int LINK_W    = $clog2(CAPACITY + 1);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int GRP_W     = 8;
  localparam int GRP_IDX_W = $clog2(GRP_W);
  localparam int NUM_GRP   = (CAPACITY + GRP_W - 1) / GRP_W;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [LINK_W-1:0]    link_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [NAME_BITS-1:0] name_t;

  localparam link_t NIL = link_t'(CAPACITY);

  // operation codes
  localparam logic [3:0] MODE_CLEAR   = 4'd0;
  localparam logic [3:0] MODE_ADD_FST = 4'd1;
  localparam logic [3:0] MODE_ADD_AFT = 4'd2;
  localparam logic [3:0] MODE_ADD_LST = 4'd3;
  localparam logic [3:0] MODE_DEL_FST = 4'd4;
  localparam logic [3:0] MODE_DEL_AFT = 4'd5;
  localparam logic [3:0] MODE_DEL_LST = 4'd6;
  localparam logic [3:0] MODE_DEL_ALL = 4'd7;
  localparam logic [3:0] MODE_CHECK   = 4'd8;

  // result status codes
  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_FULL    = 3'd1;
  localparam logic [2:0] STS_EMPTY   = 3'd2;
  localparam logic [2:0] STS_NO_NEXT = 3'd3;
  localparam logic [2:0] STS_BAD_POS = 3'd4;

  // datapath micro-operations
  localparam logic [3:0] OP_IDLE     = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_DECIDE   = 4'd2;
  localparam logic [3:0] OP_INS_LINK = 4'd3;
  localparam logic [3:0] OP_INS_FIX  = 4'd4;
  localparam logic [3:0] OP_DEL_RDA  = 4'd5;
  localparam logic [3:0] OP_UNLINK   = 4'd6;
  localparam logic [3:0] OP_CK_A     = 4'd7;
  localparam logic [3:0] OP_CK_B     = 4'd8;
  localparam logic [3:0] OP_CK_C     = 4'd9;
  localparam logic [3:0] OP_DONE     = 4'd10;

  // operation classes
  localparam logic [1:0] KIND_INS    = 2'd0;
  localparam logic [1:0] KIND_DEL    = 2'd1;
  localparam logic [1:0] KIND_DELAFT = 2'd2;
  localparam logic [1:0] KIND_CHK    = 2'd3;

  typedef struct packed {
    logic [3:0]  mode;
    logic [6:0]  position;
    logic [31:0] name_value;
    logic [7:0]  check_length;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] slot;
    logic [7:0] element_count;
    logic [6:0] mismatch_position;
  } rsp_t;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       early;
    logic       s_nil;
    logic       ck_stop;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/adll_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module adll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/adll_ctrl.sv =====
// Controller: sequences the micro-operations of one list operation.
`default_nettype none
module adll_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire adll_pkg::sts_t sts,
  output adll_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECIDE   = 4'd1;
  localparam logic [3:0] S_INS_LINK = 4'd2;
  localparam logic [3:0] S_INS_FIX  = 4'd3;
  localparam logic [3:0] S_DEL_RDA  = 4'd4;
  localparam logic [3:0] S_UNLINK   = 4'd5;
  localparam logic [3:0] S_CK_A     = 4'd6;
  localparam logic [3:0] S_CK_B     = 4'd7;
  localparam logic [3:0] S_CK_C     = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state, state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = adll_pkg::OP_IDLE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = adll_pkg::OP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.op = adll_pkg::OP_DECIDE;
        if (sts.early) begin
          state_next = S_DONE;
        end else begin
          case (sts.kind)
            adll_pkg::KIND_INS:    state_next = S_INS_LINK;
            adll_pkg::KIND_DEL:    state_next = S_UNLINK;
            adll_pkg::KIND_DELAFT: state_next = S_DEL_RDA;
            default:               state_next = S_CK_A;
          endcase
        end
      end
      S_INS_LINK: begin
        cmd.op     = adll_pkg::OP_INS_LINK;
        state_next = S_INS_FIX;
      end
      S_INS_FIX: begin
        cmd.op     = adll_pkg::OP_INS_FIX;
        state_next = S_DONE;
      end
      S_DEL_RDA: begin
        cmd.op     = adll_pkg::OP_DEL_RDA;
        state_next = sts.s_nil ? S_DONE : S_UNLINK;
      end
      S_UNLINK: begin
        cmd.op     = adll_pkg::OP_UNLINK;
        state_next = S_DONE;
      end
      S_CK_A: begin
        cmd.op     = adll_pkg::OP_CK_A;
        state_next = S_CK_B;
      end
      S_CK_B: begin
        cmd.op     = adll_pkg::OP_CK_B;
        state_next = S_CK_C;
      end
      S_CK_C: begin
        cmd.op     = adll_pkg::OP_CK_C;
        state_next = sts.ck_stop ? S_DONE : S_CK_A;
      end
      S_DONE: begin
        cmd.op = adll_pkg::OP_DONE;
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/adll_dp.sv =====
// Datapath: link and tag RAMs, free marks, head/tail/count and result register.
`default_nettype none
module adll_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire adll_pkg::cmd_t cmd,
  output adll_pkg::sts_t      sts,
  input  wire adll_pkg::req_t req,
  input  wire logic           rsp_stall,
  output logic                rsp_valid,
  output adll_pkg::rsp_t      rsp
);

  adll_pkg::req_t  it;
  adll_pkg::link_t head, tail, at, nx;
  adll_pkg::cnt_t  count;
  logic [adll_pkg::CAPACITY-1:0] free;
  adll_pkg::idx_t  s, f, t, lf, dec_slot, pos_idx;
  adll_pkg::name_t name_f;
  logic [6:0]      pairs, ck_i, res_mism, ck_pairs;
  logic [2:0]      res_status, early_status;
  adll_pkg::idx_t  res_slot;

  logic [adll_pkg::NUM_GRP*adll_pkg::GRP_W-1:0] free_pad;
  logic [adll_pkg::NUM_GRP-1:0]                 grp_any;
  logic [adll_pkg::GRP_IDX_W-1:0]               grp_idx [adll_pkg::NUM_GRP];
  logic [adll_pkg::GRP_IDX_W-1:0]               grp_idx_next [adll_pkg::NUM_GRP];

  adll_pkg::link_t nl_wdata, nl_rdata, pl_wdata, pl_rdata, ins_at, ins_nx;
  adll_pkg::idx_t  nl_waddr, nl_raddr, pl_waddr, pl_raddr, nm_raddr;
  logic            nl_we, pl_we, nm_we;
  adll_pkg::name_t nm_rdata;

  logic pos_ok, full, empty, is_clear, mismatch, out_free;
  logic [31:0] ck_n;

  adll_ram #(.WIDTH(adll_pkg::LINK_W), .DEPTH(adll_pkg::CAPACITY)) u_next (
    .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
    .raddr(nl_raddr), .rdata(nl_rdata));
  adll_ram #(.WIDTH(adll_pkg::LINK_W), .DEPTH(adll_pkg::CAPACITY)) u_prev (
    .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
    .raddr(pl_raddr), .rdata(pl_rdata));
  adll_ram #(.WIDTH(adll_pkg::NAME_BITS), .DEPTH(adll_pkg::CAPACITY)) u_name (
    .clk(clk), .we(nm_we), .waddr(s), .wdata(adll_pkg::name_t'(it.name_value)),
    .raddr(nm_raddr), .rdata(nm_rdata));

  // lowest free slot: registered per-group search, then group priority
  always_comb begin
    free_pad = '0;
    free_pad[adll_pkg::CAPACITY-1:0] = free;
  end

  always_comb begin
    for (int g = 0; g < adll_pkg::NUM_GRP; g++) begin
      grp_idx_next[g] = '0;
      for (int j = adll_pkg::GRP_W - 1; j >= 0; j--) begin
        if (free_pad[g*adll_pkg::GRP_W + j]) begin
          grp_idx_next[g] = adll_pkg::GRP_IDX_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < adll_pkg::NUM_GRP; g++) begin
      grp_any[g] <= |free_pad[g*adll_pkg::GRP_W +: adll_pkg::GRP_W];
      grp_idx[g] <= grp_idx_next[g];
    end
  end

  always_comb begin
    lf = '0;
    for (int g = adll_pkg::NUM_GRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        lf = adll_pkg::idx_t'(g * adll_pkg::GRP_W + int'(grp_idx[g]));
      end
    end
  end

  // decode of the held operation
  assign pos_idx  = adll_pkg::idx_t'(it.position);
  assign pos_ok   = (32'(it.position) < 32'(adll_pkg::CAPACITY)) && !free[pos_idx];
  assign full     = (count == adll_pkg::cnt_t'(adll_pkg::CAPACITY));
  assign empty    = (count == '0) || (head == adll_pkg::NIL);
  assign is_clear = (it.mode == adll_pkg::MODE_CLEAR) || (it.mode == adll_pkg::MODE_DEL_ALL);
  assign ck_n     = (32'(it.check_length) < 32'(count)) ? 32'(it.check_length) : 32'(count);
  assign ck_pairs = 7'(ck_n >> 1);
  assign mismatch = (nm_rdata != name_f);
  assign out_free = !rsp_valid || !rsp_stall;
  assign ins_nx   = (at == adll_pkg::NIL) ? head : nl_rdata;

  always_comb begin
    ins_at = tail;
    if (it.mode == adll_pkg::MODE_ADD_FST) begin
      ins_at = adll_pkg::NIL;
    end else if (it.mode == adll_pkg::MODE_ADD_AFT) begin
      ins_at = adll_pkg::link_t'(it.position);
    end
  end

  always_comb begin
    sts.kind     = adll_pkg::KIND_CHK;
    sts.early    = 1'b1;
    sts.s_nil    = (nl_rdata == adll_pkg::NIL);
    sts.ck_stop  = mismatch || ((ck_i + 7'd1) == pairs);
    sts.out_free = out_free;
    early_status = adll_pkg::STS_OK;
    dec_slot     = lf;
    case (it.mode)
      adll_pkg::MODE_ADD_FST, adll_pkg::MODE_ADD_LST: begin
        sts.kind     = adll_pkg::KIND_INS;
        sts.early    = full;
        early_status = full ? adll_pkg::STS_FULL : adll_pkg::STS_OK;
      end
      adll_pkg::MODE_ADD_AFT: begin
        sts.kind     = adll_pkg::KIND_INS;
        sts.early    = full || !pos_ok;
        early_status = full ? adll_pkg::STS_FULL :
                       (!pos_ok ? adll_pkg::STS_BAD_POS : adll_pkg::STS_OK);
      end
      adll_pkg::MODE_DEL_FST, adll_pkg::MODE_DEL_LST: begin
        sts.kind     = adll_pkg::KIND_DEL;
        sts.early    = empty;
        early_status = empty ? adll_pkg::STS_EMPTY : adll_pkg::STS_OK;
        dec_slot     = adll_pkg::idx_t'((it.mode == adll_pkg::MODE_DEL_FST) ? head : tail);
      end
      adll_pkg::MODE_DEL_AFT: begin
        sts.kind     = adll_pkg::KIND_DELAFT;
        sts.early    = !pos_ok;
        early_status = !pos_ok ? adll_pkg::STS_BAD_POS : adll_pkg::STS_OK;
      end
      adll_pkg::MODE_CHECK: begin
        sts.kind  = adll_pkg::KIND_CHK;
        sts.early = (ck_pairs == '0);
      end
      default: begin
        sts.early = 1'b1;
      end
    endcase
  end

  // RAM port selection
  always_comb begin
    nl_raddr = s;
    pl_raddr = s;
    nm_raddr = f;
    nl_we    = 1'b0;
    pl_we    = 1'b0;
    nm_we    = 1'b0;
    nl_waddr = s;
    pl_waddr = s;
    nl_wdata = ins_nx;
    pl_wdata = at;
    case (cmd.op)
      adll_pkg::OP_DECIDE: begin
        nl_raddr = (it.mode == adll_pkg::MODE_DEL_AFT) ? pos_idx :
                   ((sts.kind == adll_pkg::KIND_INS) ? adll_pkg::idx_t'(ins_at) : dec_slot);
        pl_raddr = dec_slot;
      end
      adll_pkg::OP_DEL_RDA: begin
        nl_raddr = adll_pkg::idx_t'(nl_rdata);
        pl_raddr = adll_pkg::idx_t'(nl_rdata);
      end
      adll_pkg::OP_INS_LINK: begin
        nl_we = 1'b1;
        pl_we = 1'b1;
        nm_we = 1'b1;
      end
      adll_pkg::OP_INS_FIX: begin
        nl_we    = (at != adll_pkg::NIL);
        nl_waddr = adll_pkg::idx_t'(at);
        nl_wdata = adll_pkg::link_t'(s);
        pl_we    = (nx != adll_pkg::NIL);
        pl_waddr = adll_pkg::idx_t'(nx);
        pl_wdata = adll_pkg::link_t'(s);
      end
      adll_pkg::OP_UNLINK: begin
        nl_we    = (pl_rdata != adll_pkg::NIL);
        nl_waddr = adll_pkg::idx_t'(pl_rdata);
        nl_wdata = nl_rdata;
        pl_we    = (nl_rdata != adll_pkg::NIL);
        pl_waddr = adll_pkg::idx_t'(nl_rdata);
        pl_wdata = pl_rdata;
      end
      adll_pkg::OP_CK_A: begin
        nl_raddr = f;
        pl_raddr = t;
        nm_raddr = f;
      end
      adll_pkg::OP_CK_B: begin
        nm_raddr = t;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free      <= '1;
      head      <= adll_pkg::NIL;
      tail      <= adll_pkg::NIL;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // a result taken in the same cycle as a new result load is covered by OP_DONE
      if (rsp_valid && !rsp_stall && (cmd.op != adll_pkg::OP_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (cmd.op)
        adll_pkg::OP_LOAD: it <= req;
        adll_pkg::OP_DECIDE: begin
          res_status <= early_status;
          res_slot   <= '0;
          res_mism   <= '0;
          s          <= dec_slot;
          at         <= ins_at;
          pairs      <= ck_pairs;
          ck_i       <= '0;
          f          <= adll_pkg::idx_t'(head);
          t          <= adll_pkg::idx_t'(tail);
          if (is_clear) begin
            free  <= '1;
            head  <= adll_pkg::NIL;
            tail  <= adll_pkg::NIL;
            count <= '0;
          end
        end
        adll_pkg::OP_INS_LINK: begin
          nx <= ins_nx;
          if (at == adll_pkg::NIL) head <= adll_pkg::link_t'(s);
          if (ins_nx == adll_pkg::NIL) tail <= adll_pkg::link_t'(s);
        end
        adll_pkg::OP_INS_FIX: begin
          count    <= count + 1'b1;
          free[s]  <= 1'b0;
          res_slot <= s;
        end
        adll_pkg::OP_DEL_RDA: begin
          s <= adll_pkg::idx_t'(nl_rdata);
          if (nl_rdata == adll_pkg::NIL) res_status <= adll_pkg::STS_NO_NEXT;
        end
        adll_pkg::OP_UNLINK: begin
          if (pl_rdata == adll_pkg::NIL) head <= nl_rdata;
          if (nl_rdata == adll_pkg::NIL) tail <= pl_rdata;
          free[s]  <= 1'b1;
          count    <= count - 1'b1;
          res_slot <= s;
        end
        adll_pkg::OP_CK_B: begin
          name_f <= nm_rdata;
          f      <= adll_pkg::idx_t'(nl_rdata);
          t      <= adll_pkg::idx_t'(pl_rdata);
        end
        adll_pkg::OP_CK_C: begin
          if (mismatch) res_mism <= ck_i + 7'd1;
          ck_i <= ck_i + 7'd1;
        end
        adll_pkg::OP_DONE: begin
          if (out_free) begin
            rsp_valid                 <= 1'b1;
            rsp.status                <= res_status;
            rsp.slot                  <= 7'(res_slot);
            rsp.element_count         <= 8'(count);
            rsp.mismatch_position     <= res_mism;
          end
        end
        default: ;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= adll_pkg::CAPACITY)
    else $error("element count above capacity");

  a_head_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == adll_pkg::OP_IDLE) |-> ((head == adll_pkg::NIL) == (count == '0)))
    else $error("head link disagrees with element count");

  a_tail_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == adll_pkg::OP_IDLE) |-> ((tail == adll_pkg::NIL) == (count == '0)))
    else $error("tail link disagrees with element count");

  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == adll_pkg::OP_INS_FIX) |-> free[s])
    else $error("allocated slot was not free");

endmodule
`default_nettype wire

// ===== hdl/array_doubly_linked_list.sv =====
// Top level: doubly linked list of name tags held in slot RAMs.
// Usage:
//   req channel (req_valid/req_stall/req) carries one operation per
//   transaction: clear, insert first/after/last, delete first/after/last,
//   delete all, or mirror check. rsp channel (rsp_valid/rsp_stall/rsp)
//   returns exactly one result transaction per request.
// Sequence: accept cycle, then decode and a short micro-sequence, then a
//   result register load. Clear, unknown and rejected ops go from decode
//   straight to the result load; delete after skips the unlink when nothing
//   follows the position. A mirror check compares up to 64 pairs. One
//   operation is handled at a time: the next request is taken in the cycle
//   after the result register loads. Each list step waits on a registered
//   RAM read; each pair of the check needs two tag reads.
// Reset (rst, synchronous): all slots free, list empty, count zero,
//   no result pending. Link and tag RAMs are not cleared; only data read from
//   slots in the list is ever used. The free slot search is a registered group
//   encoder refreshed every cycle.
// Stall: a finished result waits in the rsp register while rsp_stall is
//   high; a new request may be accepted meanwhile, and its result is held
//   internally until the rsp register frees up. req_stall is high while
//   an operation is in flight.
`default_nettype none
module array_doubly_linked_list (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire adll_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output adll_pkg::rsp_t      rsp
);

  adll_pkg::cmd_t cmd;
  adll_pkg::sts_t sts;

  // sequencer
  adll_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // list storage and result register
  adll_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire
